>>> design/amap_pkg.sv
// Shared types and constants for the ADC moisture average and calibration block.
`default_nettype none
package amap_pkg;

    localparam int ADC_W   = 12;   // converter reading width
    localparam int TOTAL_W = 18;   // ring total, holds up to 64 full-scale readings
    localparam int DIV_W   = 24;   // divider dividend / quotient width
    localparam int PCT_W   = 7;
    localparam int LVL_W   = 3;

    localparam logic [ADC_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [ADC_W-1:0] MV_SCALE   = 12'd3300;
    localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;

    // avg * 3300 / 4095 reduces to avg * 220 / 273; the rounded-up
    // reciprocal of 273 at 2^29 is exact for every 12-bit average
    localparam int MV_SHIFT  = 29;
    localparam int MV_MULT_W = 29;
    localparam logic [MV_MULT_W-1:0] MV_MULT =
        MV_MULT_W'((((64'd1 << MV_SHIFT) + 64'd272) / 64'd273) * 64'd220);

    localparam logic [PCT_W-1:0] LVL_T1 = 7'd20;
    localparam logic [PCT_W-1:0] LVL_T2 = 7'd40;
    localparam logic [PCT_W-1:0] LVL_T3 = 7'd60;
    localparam logic [PCT_W-1:0] LVL_T4 = 7'd80;

    // configuration register indexes
    localparam logic REG_DRY = 1'b0;
    localparam logic REG_WET = 1'b1;

    typedef enum logic {
        F_IDLE,
        F_UPD
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_AVG,
        B_PREP,
        B_MAP,
        B_OUT
    } t_back_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [ADC_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic [ADC_W-1:0] dry;
        logic [ADC_W-1:0] wet;
    } t_cal;

endpackage
`default_nettype wire

>>> design/amap_div.sv
// Radix-4 restoring divider, two quotient bits per cycle.
`default_nettype none
module amap_div
    import amap_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quo
);

    localparam int STEPS = DIV_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [ADC_W-1:0] r_rem, n_rem;
    logic [ADC_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    always_comb begin
        logic [ADC_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[DIV_W-1]};
            if (trial >= {1'b0, r_div}) begin
                n_rem = ADC_W'(trial - {1'b0, r_div});
                n_quo = {n_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[ADC_W-1:0];
                n_quo = {n_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    // done fires on the last step; the quotient is final in the following cycle
    assign o_done = r_busy && (r_cnt == CNT_W'(STEPS - 1));
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

>>> design/amap_fifo.sv
// Two-entry queue of ring totals between the front and back halves.
`default_nettype none
module amap_fifo
    import amap_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [TOTAL_W-1:0] i_data,
    input  wire logic               i_pop,
    output logic [TOTAL_W-1:0]      o_data,
    output logic                    o_empty,
    output logic                    o_full
);

    logic [TOTAL_W-1:0] r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule
`default_nettype wire

>>> design/amap_front.sv
// Front half: accepts samples, updates the sample ring and the running total.
`default_nettype none
module amap_front
    import amap_pkg::*;
#(
    parameter int RING_DEPTH = 16
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [ADC_W-1:0]   i_sample,
    input  wire logic               i_fifo_full,
    output logic                    o_full,
    output logic                    o_fifo_push,
    output logic [TOTAL_W-1:0]      o_total
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    t_front_state r_state, n_state;

    logic [ADC_W-1:0]   r_ring [RING_DEPTH];
    logic               r_vld  [RING_DEPTH];
    logic [ADC_W-1:0]   r_rd;
    logic               r_rd_vld;
    logic [ADC_W-1:0]   r_sample;
    logic [SLOT_W-1:0]  r_slot;
    logic [TOTAL_W-1:0] r_total;

    logic               accept;
    logic               upd;
    logic [ADC_W-1:0]   old_val;
    logic [TOTAL_W-1:0] n_total;

    always_comb begin
        n_state = r_state;
        o_full  = 1'b1;
        accept  = 1'b0;
        upd     = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_full = i_fifo_full;
                if (i_push && !i_fifo_full) begin
                    accept  = 1'b1;
                    n_state = F_UPD;
                end
            end
            F_UPD: begin
                upd     = 1'b1;
                n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // entries never written since reset read as zero
    assign old_val = r_rd_vld ? r_rd : '0;
    assign n_total = r_total - TOTAL_W'(old_val) + TOTAL_W'(r_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_slot  <= '0;
            r_total <= '0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (upd) begin
                r_total        <= n_total;
                r_vld[r_slot]  <= 1'b1;
                if (r_slot == SLOT_W'(RING_DEPTH - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
        end
    end

    // ring memory: registered read of the slot about to be overwritten
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
            r_rd     <= r_ring[r_slot];
            r_rd_vld <= r_vld[r_slot];
        end
        if (upd) begin
            r_ring[r_slot] <= r_sample;
        end
    end

    assign o_fifo_push = upd;
    assign o_total     = n_total;

endmodule
`default_nettype wire

>>> design/amap_back.sv
// Back half: average, millivolt scale, calibrated percentage and level code.
`default_nettype none
module amap_back
    import amap_pkg::*;
#(
    parameter int RING_DEPTH = 16
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cal               i_cal,
    input  wire logic               i_fifo_empty,
    input  wire logic [TOTAL_W-1:0] i_total,
    output logic                    o_fifo_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic [ADC_W-1:0]        o_avg_raw,
    output logic [ADC_W-1:0]        o_voltage_mv,
    output logic [PCT_W-1:0]        o_moisture_pct,
    output logic [LVL_W-1:0]        o_level
);

    // total / RING_DEPTH as a multiply by the rounded-up reciprocal;
    // exact for every total below 2^TOTAL_W
    localparam int AVG_SH = TOTAL_W + $clog2(RING_DEPTH);
    localparam int AVG_MW = TOTAL_W + 2;
    localparam int AVG_PW = TOTAL_W + AVG_MW;
    localparam logic [AVG_MW-1:0] AVG_MULT = AVG_MW'(
        ((longint'(1) << AVG_SH) + longint'(RING_DEPTH) - longint'(1))
        / longint'(RING_DEPTH));
    localparam int MV_PW = ADC_W + MV_MULT_W;

    t_back_state r_state, n_state;

    t_div_req          req;
    logic              done;
    logic [DIV_W-1:0]  quo;

    logic [AVG_PW-1:0] avg_prod;
    logic [ADC_W-1:0]  avg;
    logic [MV_PW-1:0]  mv_prod;
    logic signed [ADC_W:0] num, den;
    logic [ADC_W-1:0]  num_mag, den_mag;
    logic              take_terms;

    logic [ADC_W-1:0]  r_avg;
    logic [ADC_W-1:0]  r_mv;
    logic [ADC_W-1:0]  r_num_mag;
    logic [ADC_W-1:0]  r_den_mag;
    logic              r_neg;
    logic              r_eq;
    logic              load_out;

    logic [PCT_W-1:0]  pct;
    logic [LVL_W-1:0]  lvl;

    logic              r_out_valid;
    logic [ADC_W-1:0]  r_o_avg;
    logic [ADC_W-1:0]  r_o_mv;
    logic [PCT_W-1:0]  r_o_pct;
    logic [LVL_W-1:0]  r_o_lvl;

    amap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_done  (done),
        .o_quo   (quo)
    );

    assign avg_prod = AVG_PW'(i_total) * AVG_PW'(AVG_MULT);
    assign avg      = avg_prod[AVG_SH +: ADC_W];
    assign mv_prod  = MV_PW'(r_avg) * MV_PW'(MV_MULT);

    // signed calibration terms, taken from the registered average
    assign num     = $signed({1'b0, r_avg}) - $signed({1'b0, i_cal.dry});
    assign den     = $signed({1'b0, i_cal.wet}) - $signed({1'b0, i_cal.dry});
    assign num_mag = num[ADC_W] ? ADC_W'(-num) : num[ADC_W-1:0];
    assign den_mag = den[ADC_W] ? ADC_W'(-den) : den[ADC_W-1:0];

    always_comb begin
        n_state    = r_state;
        req        = '0;
        o_fifo_pop = 1'b0;
        take_terms = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_fifo_empty) begin
                    o_fifo_pop = 1'b1;
                    n_state    = B_AVG;
                end
            end
            B_AVG: begin
                take_terms = 1'b1;
                n_state    = B_PREP;
            end
            B_PREP: begin
                req.start    = 1'b1;
                req.dividend = DIV_W'(r_num_mag) * DIV_W'(PCT_MAX);
                req.divisor  = r_den_mag;
                n_state      = B_MAP;
            end
            B_MAP: begin
                if (done) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (!r_out_valid || i_pop) begin
                    load_out = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // quotient rounds toward zero, so any negative result clamps to zero
    always_comb begin
        if (r_eq || r_neg) begin
            pct = '0;
        end else if (quo > DIV_W'(PCT_MAX)) begin
            pct = PCT_MAX;
        end else begin
            pct = quo[PCT_W-1:0];
        end
        if (pct < LVL_T1) begin
            lvl = 3'd0;
        end else if (pct < LVL_T2) begin
            lvl = 3'd1;
        end else if (pct < LVL_T3) begin
            lvl = 3'd2;
        end else if (pct < LVL_T4) begin
            lvl = 3'd3;
        end else begin
            lvl = 3'd4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fifo_pop) begin
            r_avg <= avg;
        end
        if (take_terms) begin
            r_mv      <= mv_prod[MV_SHIFT +: ADC_W];
            r_num_mag <= num_mag;
            r_den_mag <= den_mag;
            r_neg     <= num[ADC_W] ^ den[ADC_W];
            r_eq      <= (den == '0);
        end
        if (load_out) begin
            r_o_avg <= r_avg;
            r_o_mv  <= r_mv;
            r_o_pct <= pct;
            r_o_lvl <= lvl;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_avg_raw      = r_o_avg;
    assign o_voltage_mv   = r_o_mv;
    assign o_moisture_pct = r_o_pct;
    assign o_level        = r_o_lvl;

endmodule
`default_nettype wire

>>> design/adc_moisture_average_map_top.sv
// Top level of the ADC moisture average and two-point calibration block.
//
// Input queue side: drive i_sample and raise i_push; the transaction is
// taken at a clock edge where i_push is high and o_full is low.
// Result queue side: while o_empty is low the oldest result sits on
// o_avg_raw, o_voltage_mv, o_moisture_pct and o_level; i_pop takes it.
// Calibration: i_cfg_we writes i_cfg_data into dry point (index 0) or
// wet point (index 1); write only while no transaction is in flight.
//
// The front half updates a ring of RING_DEPTH readings and its running
// total in an accept state and an update state, and drops the total
// into a two-entry queue. The back half forms the average and the
// millivolt value by constant reciprocal multiplies, then runs the
// radix-4 divider for the percentage. The back half takes one total at
// a time and returns to idle only once its result is loaded, which sets
// the sustained rate. When results are not popped, the output register,
// the back half and the queue hold four transactions, then o_full rises.
// Reset (i_rst_n low, synchronous) zeroes the ring, total and queues and
// loads dry point 0 and wet point 4095.
`default_nettype none
module adc_moisture_average_map_top
    import amap_pkg::*;
#(
    parameter int RING_DEPTH = 16
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [ADC_W-1:0]   i_sample,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic [ADC_W-1:0]        o_avg_raw,
    output logic [ADC_W-1:0]        o_voltage_mv,
    output logic [PCT_W-1:0]        o_moisture_pct,
    output logic [LVL_W-1:0]        o_level,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [ADC_W-1:0]   i_cfg_data
);

    // calibration registers
    t_cal r_cal;

    // front to back queue
    logic               fifo_push;
    logic [TOTAL_W-1:0] fifo_in;
    logic               fifo_pop;
    logic [TOTAL_W-1:0] fifo_out;
    logic               fifo_empty;
    logic               fifo_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.dry <= '0;
            r_cal.wet <= FULL_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DRY: r_cal.dry <= i_cfg_data;
                REG_WET: r_cal.wet <= i_cfg_data;
                default: ;
            endcase
        end
    end

    amap_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_sample    (i_sample),
        .i_fifo_full (fifo_full),
        .o_full      (o_full),
        .o_fifo_push (fifo_push),
        .o_total     (fifo_in)
    );

    amap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (fifo_in),
        .i_pop   (fifo_pop),
        .o_data  (fifo_out),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    amap_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cal          (r_cal),
        .i_fifo_empty   (fifo_empty),
        .i_total        (fifo_out),
        .o_fifo_pop     (fifo_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_avg_raw      (o_avg_raw),
        .o_voltage_mv   (o_voltage_mv),
        .o_moisture_pct (o_moisture_pct),
        .o_level        (o_level)
    );

endmodule
`default_nettype wire

>>> verif/adc_moisture_average_map_top_tb.sv
// Self-checking testbench for the ADC moisture averaging and calibration block.
module adc_moisture_average_map_top_tb
    import amap_pkg::*;
();

    localparam int RING_DEPTH    = 16;
    localparam int SETTLE_CYCLES = 40;   // idle margin after the last result

    // level bands as reported on o_level
    localparam logic [LVL_W-1:0] BAND_ARID   = 3'd0;
    localparam logic [LVL_W-1:0] BAND_DRY    = 3'd1;
    localparam logic [LVL_W-1:0] BAND_MID    = 3'd2;
    localparam logic [LVL_W-1:0] BAND_DAMP   = 3'd3;
    localparam logic [LVL_W-1:0] BAND_SOAKED = 3'd4;

    typedef struct packed {
        logic [ADC_W-1:0] avg;
        logic [ADC_W-1:0] mv;
        logic [PCT_W-1:0] pct;
        logic [LVL_W-1:0] band;
    } t_moisture_reading;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    logic               o_full;
    logic [ADC_W-1:0]   i_sample;
    logic               i_pop;
    logic               o_empty;
    logic [ADC_W-1:0]   o_avg_raw;
    logic [ADC_W-1:0]   o_voltage_mv;
    logic [PCT_W-1:0]   o_moisture_pct;
    logic [LVL_W-1:0]   o_level;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [ADC_W-1:0]   i_cfg_data;

    // predictor state: our own copy of the sample ring and calibration
    logic [ADC_W-1:0]   ring_mem [RING_DEPTH];
    int                 ring_slot;
    logic [TOTAL_W-1:0] ring_sum;
    logic [ADC_W-1:0]   cal_dry;
    logic [ADC_W-1:0]   cal_wet;

    t_moisture_reading  pending_readings[$];

    int  err_count;
    int  sent_count;
    int  checked_count;
    int  cal_count;
    bit  burst_mode;   // sender: no gaps
    bit  pop_eager;    // receiver: no stalls

    adc_moisture_average_map_top #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_sample       (i_sample),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_avg_raw      (o_avg_raw),
        .o_voltage_mv   (o_voltage_mv),
        .o_moisture_pct (o_moisture_pct),
        .o_level        (o_level),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #20_000_000;
        $display("timeout: %0d results still outstanding", pending_readings.size());
        $display("FAIL adc_moisture_average_map_top");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Overwrite the oldest ring entry, then average, scale and map it.
    function automatic t_moisture_reading absorb_sample(input logic [ADC_W-1:0] s);
        t_moisture_reading r;
        int avg;
        int dry;
        int wet;
        int pct;
        ring_sum = ring_sum - ring_mem[ring_slot] + s;
        ring_mem[ring_slot] = s;
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        avg = ring_sum / RING_DEPTH;
        dry = cal_dry;
        wet = cal_wet;
        if (dry == wet) begin
            pct = 0;
        end else begin
            // signed quotient, truncates toward zero; inverted points allowed
            pct = ((avg - dry) * 100) / (wet - dry);
            if (pct < 0) pct = 0;
            if (pct > int'(PCT_MAX)) pct = int'(PCT_MAX);
        end
        r.avg = ADC_W'(avg);
        r.mv  = ADC_W'((avg * int'(MV_SCALE)) / int'(FULL_SCALE));
        r.pct = PCT_W'(pct);
        if (pct < int'(LVL_T1))      r.band = BAND_ARID;
        else if (pct < int'(LVL_T2)) r.band = BAND_DRY;
        else if (pct < int'(LVL_T3)) r.band = BAND_MID;
        else if (pct < int'(LVL_T4)) r.band = BAND_DAMP;
        else                         r.band = BAND_SOAKED;
        return r;
    endfunction

    // One input transaction. i_push stays high after acceptance so that
    // back-to-back items need no re-arm; a gap lowers it first.
    task automatic send_sample(input logic [ADC_W-1:0] s);
        int gap;
        int r;
        r = $urandom_range(99);
        if (burst_mode || r < 45) gap = 0;
        else if (r < 85)          gap = $urandom_range(1, 3);
        else if (r < 97)          gap = $urandom_range(4, 20);
        else                      gap = $urandom_range(30, 120);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push   <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        pending_readings.push_back(absorb_sample(s));
        sent_count++;
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_drained();
        i_push <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both calibration registers, one write each on consecutive edges.
    task automatic set_cal(input logic [ADC_W-1:0] dry, input logic [ADC_W-1:0] wet);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_DRY;
        i_cfg_data <= dry;
        @(posedge i_clk);
        cal_dry = dry;
        i_cfg_idx  <= REG_WET;
        i_cfg_data <= wet;
        @(posedge i_clk);
        cal_wet = wet;
        i_cfg_we <= 1'b0;
        cal_count++;
    endtask

    // Result side: pop with random stalls and check against the oldest
    // prediction. Outputs are read right after the edge, i.e. the values
    // that the edge itself saw.
    initial begin : result_side
        t_moisture_reading want;
        int  hold;
        int  r;
        logic pop_next;
        i_pop    = 1'b0;
        hold     = 0;
        pop_next = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) begin
                if (pending_readings.size() == 0) begin
                    flag_error($sformatf("unexpected result avg=%0d mv=%0d pct=%0d lvl=%0d",
                        o_avg_raw, o_voltage_mv, o_moisture_pct, o_level));
                end else begin
                    want = pending_readings.pop_front();
                    if (o_avg_raw !== want.avg)
                        flag_error($sformatf("result %0d avg_raw %0d, expected %0d",
                            checked_count, o_avg_raw, want.avg));
                    if (o_voltage_mv !== want.mv)
                        flag_error($sformatf("result %0d voltage_mv %0d, expected %0d",
                            checked_count, o_voltage_mv, want.mv));
                    if (o_moisture_pct !== want.pct)
                        flag_error($sformatf("result %0d moisture_pct %0d, expected %0d",
                            checked_count, o_moisture_pct, want.pct));
                    if (o_level !== want.band)
                        flag_error($sformatf("result %0d level %0d, expected %0d",
                            checked_count, o_level, want.band));
                    checked_count++;
                end
            end
            // stall pattern: runs of pops, short stalls, now and then a long one
            if (pop_eager) begin
                pop_next = 1'b1;
                hold     = 0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(99);
                if (r < 50) begin
                    pop_next = 1'b1;
                    hold     = $urandom_range(0, 30);
                end else if (r < 90) begin
                    pop_next = 1'b0;
                    hold     = $urandom_range(0, 3);
                end else begin
                    pop_next = 1'b0;
                    hold     = $urandom_range(20, 90);
                end
            end
            i_pop <= pop_next;
        end
    end

    // Right after reset the ring is mostly zeros, so averages start low.
    task automatic test_unfilled_ring();
        send_sample(FULL_SCALE);
        send_sample(FULL_SCALE);
        send_sample('0);
        send_sample(12'd1);
        send_sample(12'd2048);
        send_sample(12'hAAA);
        send_sample(12'h555);
    endtask

    // Dry equal to wet: percentage and level pinned at zero.
    task automatic test_equal_points();
        wait_drained();
        set_cal(12'd2048, 12'd2048);
        send_sample(FULL_SCALE);
        send_sample(12'd2048);
        send_sample('0);
    endtask

    // Wet below dry: lower readings read as wetter.
    task automatic test_inverted_points();
        wait_drained();
        set_cal(FULL_SCALE, '0);
        send_sample('0);
        send_sample('0);
        send_sample(FULL_SCALE);
        send_sample(FULL_SCALE);
    endtask

    // One-count window: nearly everything clamps to 0 or 100.
    task automatic test_narrow_window();
        wait_drained();
        set_cal(12'd300, 12'd301);
        send_sample(FULL_SCALE);
        send_sample('0);
        send_sample(12'd301);
        send_sample(12'd300);
    endtask

    // Mixed traffic under one calibration: constant runs (which pull the
    // average toward the run's value), uniform noise, lone extremes and
    // readings near the calibration points.
    task automatic run_random_phase(input logic [ADC_W-1:0] dry, input logic [ADC_W-1:0] wet,
                                    input int n_items, input bit eager, input bit hold_off);
        int sent;
        int kind;
        int run_len;
        int near;
        logic [ADC_W-1:0] v;
        wait_drained();
        set_cal(dry, wet);
        burst_mode = eager;
        pop_eager  = eager;
        sent = 0;
        while (sent < n_items) begin
            kind    = $urandom_range(99);
            run_len = 1;
            if (kind < 30) begin
                case ($urandom_range(3))
                    0:       v = '0;
                    1:       v = FULL_SCALE;
                    default: v = ADC_W'($urandom_range(4095));
                endcase
                run_len = $urandom_range(1, 24);
            end else if (kind < 80) begin
                v = ADC_W'($urandom_range(4095));
            end else if (kind < 90) begin
                v = $urandom_range(1) ? FULL_SCALE : '0;
            end else begin
                near = $urandom_range(1) ? int'(cal_dry) : int'(cal_wet);
                near = near + int'($urandom_range(16)) - 8;
                if (near < 0) near = 0;
                if (near > int'(FULL_SCALE)) near = int'(FULL_SCALE);
                v = ADC_W'(near);
            end
            repeat (run_len) begin
                send_sample(v);
                sent++;
                // hold the sender until the block has emptied out
                if (hold_off && sent == n_items / 2) wait_drained();
            end
        end
        burst_mode = 1'b0;
        pop_eager  = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase('0, FULL_SCALE, 125, 1'b0, 1'b1);
        run_random_phase(FULL_SCALE, '0, 125, 1'b0, 1'b0);
        run_random_phase(12'd3200, 12'd1200, 125, 1'b1, 1'b0);
        run_random_phase('0, '0, 100, 1'b0, 1'b0);
        run_random_phase(FULL_SCALE, FULL_SCALE, 100, 1'b0, 1'b0);
        run_random_phase(12'd1500, 12'd1501, 110, 1'b0, 1'b0);
        run_random_phase(ADC_W'($urandom_range(4095)), ADC_W'($urandom_range(4095)),
                         110, 1'b0, 1'b0);
        run_random_phase(ADC_W'($urandom_range(2047)), ADC_W'($urandom_range(2048, 4095)),
                         110, 1'b0, 1'b1);
        run_random_phase(12'd1000, 12'd2600, 110, 1'b0, 1'b0);
    endtask

    initial begin : stimulus
        i_rst_n    = 1'b0;
        i_push     = 1'b0;
        i_sample   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_DRY;
        i_cfg_data = '0;
        burst_mode = 1'b0;
        pop_eager  = 1'b0;
        err_count     = 0;
        sent_count    = 0;
        checked_count = 0;
        cal_count     = 0;
        foreach (ring_mem[k]) ring_mem[k] = '0;
        ring_slot = 0;
        ring_sum  = '0;
        cal_dry   = '0;
        cal_wet   = FULL_SCALE;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unfilled_ring();
        test_equal_points();
        test_inverted_points();
        test_narrow_window();
        test_random_traffic();
        wait_drained();

        $display("run: %0d samples sent, %0d results checked, %0d calibration settings",
                 sent_count, checked_count, cal_count);
        $display("run: normal, inverted, equal and one-count calibration windows, %0d errors",
                 err_count);
        if (err_count == 0) begin
            $display("PASS adc_moisture_average_map_top");
        end else begin
            $display("FAIL adc_moisture_average_map_top");
        end
        $finish;
    end

endmodule
